/* hw/rtl/ppts_pkg.sv */
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared constants for the perspective projection core: default fraction
// width, ratio width, screen dimension width and configuration register indexes.
// ----------------------------------------------------------------------------
package ppts_pkg;

  // Default number of fractional bits of all fixed point values.
  localparam int FRAC_BITS_DEF = 16;

  // Ratio magnitude is clamped to 2^46, so it needs 47 bits.
  localparam int QUOT_BITS = 47;

  // Screen size register: width in the low half, height in the high half.
  localparam int SCREEN_DIM_W = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ROW0_XY   = 3'd0;
  localparam cfg_idx_t REG_ROW0_ZT   = 3'd1;
  localparam cfg_idx_t REG_ROW1_XY   = 3'd2;
  localparam cfg_idx_t REG_ROW1_ZT   = 3'd3;
  localparam cfg_idx_t REG_ROW3_XY   = 3'd4;
  localparam cfg_idx_t REG_ROW3_ZT   = 3'd5;
  localparam cfg_idx_t REG_SCREEN    = 3'd6;
  localparam cfg_idx_t REG_LOADED    = 3'd7;

endpackage

/* hw/rtl/ppts_fifo.sv */
// ----------------------------------------------------------------------------
// ppts_fifo
// Small register based queue with full and empty flags.
// ----------------------------------------------------------------------------
module ppts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> !empty)
    else $error("queue empty after a lone push");
  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !push) |=> !full)
    else $error("queue full after a lone pop");
`endif

endmodule

/* hw/rtl/ppts_front.sv */
// ----------------------------------------------------------------------------
// ppts_front
// Front end: takes input beats, forms clip x, y and w as dot products with
// the configured matrix rows and classifies the point as visible or not.
// ----------------------------------------------------------------------------
module ppts_front
  import ppts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CLIP_W   = 66 - FRAC_BITS,
  localparam int BEAT_W   = 1 + 3 * CLIP_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [31:0]       in_pos_x,
  input  logic [31:0]       in_pos_y,
  input  logic [31:0]       in_pos_z,
  input  logic [63:0]       row0_xy,
  input  logic [63:0]       row0_zt,
  input  logic [63:0]       row1_xy,
  input  logic [63:0]       row1_zt,
  input  logic [63:0]       row3_xy,
  input  logic [63:0]       row3_zt,
  input  logic              matrix_loaded,
  output logic              q_push,
  output logic [BEAT_W-1:0] q_wdata,
  input  logic              q_full
);

  localparam int PROD_W = 64 - FRAC_BITS;
  localparam int W100_W = CLIP_W + 7;
  localparam logic signed [W100_W-1:0] ONE_W = W100_W'(1) << FRAC_BITS;

  logic               en;
  logic               s0_v_r, s1_v_r, s2_v_r;
  logic [31:0]        px_r, py_r, pz_r;
  logic [31:0]        coef [0:8];
  logic [31:0]        trans [0:2];
  logic [PROD_W-1:0]  prod_r [0:8];
  logic [63:0]        prod_full [0:8];
  logic [CLIP_W-1:0]  clip_nxt [0:2];
  logic [CLIP_W-1:0]  clip_r [0:2];
  logic signed [W100_W-1:0] w_ext, w100;
  logic               vis;

  assign en      = !q_full;
  assign in_full = q_full;

  // Coefficients: rows 0, 1 and 3 of the matrix, x, y, z per row.
  assign coef[0]  = row0_xy[31:0];
  assign coef[1]  = row0_xy[63:32];
  assign coef[2]  = row0_zt[31:0];
  assign coef[3]  = row1_xy[31:0];
  assign coef[4]  = row1_xy[63:32];
  assign coef[5]  = row1_zt[31:0];
  assign coef[6]  = row3_xy[31:0];
  assign coef[7]  = row3_xy[63:32];
  assign coef[8]  = row3_zt[31:0];
  assign trans[0] = row0_zt[63:32];
  assign trans[1] = row1_zt[63:32];
  assign trans[2] = row3_zt[63:32];

  // Nine signed products; the floor to the output fraction is a plain shift.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      case (i % 3)
        0:       prod_full[i] = 64'($signed(coef[i]) * $signed(px_r));
        1:       prod_full[i] = 64'($signed(coef[i]) * $signed(py_r));
        default: prod_full[i] = 64'($signed(coef[i]) * $signed(pz_r));
      endcase
    end
  end

  // Sum of three floored products and the translation per row.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_nxt[r] = {{2{prod_r[3*r][PROD_W-1]}}, prod_r[3*r]}
                  + {{2{prod_r[3*r+1][PROD_W-1]}}, prod_r[3*r+1]}
                  + {{2{prod_r[3*r+2][PROD_W-1]}}, prod_r[3*r+2]}
                  + {{(CLIP_W-32){trans[r][31]}}, trans[r]};
    end
  end

  // Visibility: matrix present and 100*w at least one.
  always_comb begin
    w_ext = $signed({{7{clip_r[2][CLIP_W-1]}}, clip_r[2]});
    w100  = (w_ext <<< 6) + (w_ext <<< 5) + (w_ext <<< 2);
    vis   = matrix_loaded && (w100 >= ONE_W);
  end

  assign q_push  = s2_v_r && en;
  assign q_wdata = {vis, clip_r[0], clip_r[1], clip_r[2]};

  // Stage valids; the whole front stalls while the queue is full.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_push;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_push) begin
        px_r <= in_pos_x;
        py_r <= in_pos_y;
        pz_r <= in_pos_z;
      end
      for (int i = 0; i < 9; i++) begin
        prod_r[i] <= prod_full[i][63:FRAC_BITS];
      end
      for (int r = 0; r < 3; r++) begin
        clip_r[r] <= clip_nxt[r];
      end
    end
  end

endmodule

/* hw/rtl/ppts_div.sv */
// ----------------------------------------------------------------------------
// ppts_div
// Pipelined restoring divider: one quotient bit per stage, giving
// floor(num * 2^FRAC_BITS / den) clamped to 2^46, plus a sideband.
// ----------------------------------------------------------------------------
module ppts_div
  import ppts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int M_W       = 66 - FRAC_BITS,
  parameter int SIDE_W    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_v,
  input  logic [M_W-1:0]       num,
  input  logic [M_W-1:0]       den,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_v,
  output logic [QUOT_BITS-1:0] quo,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int QB = QUOT_BITS;
  localparam logic [QB-1:0] LIM = {1'b1, {(QB-1){1'b0}}};

  logic [M_W-1:0]    rem_r  [0:QB];
  logic [M_W-1:0]    den_r  [0:QB];
  logic [QB-1:0]     bits_r [0:QB];
  logic [QB-1:0]     quo_r  [0:QB];
  logic              ovf_r  [0:QB];
  logic [SIDE_W-1:0] side_r [0:QB];
  logic              v_r    [0:QB];

  logic [M_W-1:0]    hi;
  logic              ovf;
  logic [M_W:0]      trial [0:QB-1];
  logic [M_W:0]      diff  [0:QB-1];
  logic              ge    [0:QB-1];
  logic [M_W-1:0]    rem_nxt [0:QB-1];

  // Quotient at or above 2^47 shows up before the first bit.
  assign hi  = num >> (QB - FRAC_BITS);
  assign ovf = (hi >= den);

  // One trial subtraction per stage.
  always_comb begin
    for (int i = 0; i < QB; i++) begin
      trial[i]   = {rem_r[i], bits_r[i][QB-1]};
      diff[i]    = trial[i] - {1'b0, den_r[i]};
      ge[i]      = (trial[i] >= {1'b0, den_r[i]});
      rem_nxt[i] = ge[i] ? diff[i][M_W-1:0] : trial[i][M_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 0; i < QB; i++) begin
        v_r[i+1] <= v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= ovf ? '0 : hi;
      den_r[0]  <= den;
      bits_r[0] <= {num[QB-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
      quo_r[0]  <= '0;
      ovf_r[0]  <= ovf;
      side_r[0] <= in_side;
      for (int i = 0; i < QB; i++) begin
        rem_r[i+1]  <= rem_nxt[i];
        den_r[i+1]  <= den_r[i];
        bits_r[i+1] <= {bits_r[i][QB-2:0], 1'b0};
        quo_r[i+1]  <= {quo_r[i][QB-2:0], ge[i]};
        ovf_r[i+1]  <= ovf_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  // Clamp the magnitude to 2^46.
  assign out_v    = v_r[QB];
  assign out_side = side_r[QB];
  assign quo      = (ovf_r[QB] || quo_r[QB][QB-1]) ? LIM : quo_r[QB];

endmodule

/* hw/rtl/ppts_back.sv */
// ----------------------------------------------------------------------------
// ppts_back
// Back end: divides clip x and y by w, maps the ratios to pixel
// coordinates, saturates them and writes result beats to the output queue.
// ----------------------------------------------------------------------------
module ppts_back
  import ppts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int CLIP_W   = 66 - FRAC_BITS,
  localparam int BEAT_W   = 1 + 3 * CLIP_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic [BEAT_W-1:0] q_rdata,
  input  logic [31:0]       screen_size,
  output logic              o_push,
  output logic [64:0]       o_wdata,
  input  logic              o_full
);

  localparam int QB    = QUOT_BITS;
  localparam int DW    = SCREEN_DIM_W;
  localparam int PW    = QB + DW;
  localparam int SUM_W = 66;
  localparam logic [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -(SUM_W'(1) << 31);

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic              en;
  logic              b0_v_r;
  logic [CLIP_W-1:0] mag_x_r, mag_y_r, den_r;
  logic              sgn_x_r, sgn_y_r, vis_r;
  logic [CLIP_W-1:0] cx, cy, w;
  logic              vis_in;

  logic              dx_v, dy_v;
  logic [QB-1:0]     qx, qy;
  logic [1:0]        side_x;
  logic              side_y;

  logic              m_v_r, m_vis_r, m_sx_r, m_sy_r;
  logic [PW-1:0]     prod_x_r, prod_y_r;

  logic              f_v_r, f_vis_r;
  logic [31:0]       f_sx_r, f_sy_r;

  logic [DW-1:0]     scr_w, scr_h;
  logic [SUM_W-1:0]  px, py, base_x, base_y, sum_x, sum_y;

  assign en     = !o_full;
  assign q_pop  = en && !q_empty;
  assign vis_in = q_rdata[BEAT_W-1];
  assign cx     = q_rdata[3*CLIP_W-1:2*CLIP_W];
  assign cy     = q_rdata[2*CLIP_W-1:CLIP_W];
  assign w      = q_rdata[CLIP_W-1:0];
  assign scr_w  = screen_size[DW-1:0];
  assign scr_h  = screen_size[2*DW-1:DW];

  // Valids of the back stages; all of them stall on a full output queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
    end else if (en) begin
      b0_v_r <= q_pop;
      m_v_r  <= dx_v;
      f_v_r  <= m_v_r;
    end
  end

  // Split each numerator into magnitude and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      mag_x_r <= cx[CLIP_W-1] ? CLIP_W'(-cx) : cx;
      mag_y_r <= cy[CLIP_W-1] ? CLIP_W'(-cy) : cy;
      sgn_x_r <= cx[CLIP_W-1];
      sgn_y_r <= cy[CLIP_W-1];
      den_r   <= w;
      vis_r   <= vis_in;
    end
  end

  ppts_div #(
    .FRAC_BITS (FRAC_BITS),
    .M_W       (CLIP_W),
    .SIDE_W    (2)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (b0_v_r),
    .num      (mag_x_r),
    .den      (den_r),
    .in_side  ({vis_r, sgn_x_r}),
    .out_v    (dx_v),
    .quo      (qx),
    .out_side (side_x)
  );

  ppts_div #(
    .FRAC_BITS (FRAC_BITS),
    .M_W       (CLIP_W),
    .SIDE_W    (1)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (b0_v_r),
    .num      (mag_y_r),
    .den      (den_r),
    .in_side  (sgn_y_r),
    .out_v    (dy_v),
    .quo      (qy),
    .out_side (side_y)
  );

  // Scale the ratio magnitudes by the screen dimensions.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= PW'(qx) * PW'(scr_w);
      prod_y_r <= PW'(qy) * PW'(scr_h);
      m_vis_r  <= side_x[1];
      m_sx_r   <= side_x[0];
      m_sy_r   <= side_y;
    end
  end

  // Pixel mapping: halve the sums with floor, then saturate.
  always_comb begin
    px     = SUM_W'(prod_x_r);
    py     = SUM_W'(prod_y_r);
    base_x = (SUM_W'(scr_w) << FRAC_BITS) + ONE_S;
    base_y = (SUM_W'(scr_h) << FRAC_BITS) - ONE_S;
    sum_x  = base_x + (m_sx_r ? -px : px);
    sum_y  = base_y + (m_sy_r ? py : -py);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_vis_r <= m_vis_r;
      f_sx_r  <= m_vis_r ? sat32($signed(sum_x) >>> 1) : '0;
      f_sy_r  <= m_vis_r ? sat32($signed(sum_y) >>> 1) : '0;
    end
  end

  assign o_push  = f_v_r && en;
  assign o_wdata = {f_vis_r, f_sx_r, f_sy_r};

`ifndef NO_ASSERTIONS
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_v == dy_v)
    else $error("x and y dividers out of step");
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && !f_vis_r) |-> (f_sx_r == '0 && f_sy_r == '0))
    else $error("rejected point with nonzero coordinates");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (f_v_r && !en) |=> (f_v_r && $stable(o_wdata)))
    else $error("result beat lost during a stall");
`endif

endmodule

/* hw/rtl/perspective_project_to_screen_core.sv */
// ----------------------------------------------------------------------------
// perspective_project_to_screen_core
// Projects world points (fixed point) to screen pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (pos x, y, z) enter with in_push while in_full is low.
//   Result beats (visible, screen x, screen y) wait on the out_ ports while
//   out_empty is low and leave with out_pop. One result per input, in order.
//   Matrix rows, screen size and the loaded flag are written on the cfg_
//   port by index while the block is idle.
// Timing:
//   One beat per cycle in and out when the receiver keeps popping. A point
//   passes from acceptance to the output through these stages in order:
//   three front stages, the middle queue, a sign split stage, a divider
//   load stage and 47 divider stages (one quotient bit each), two mapping
//   stages and the output queue.
// Reset:
//   Synchronous, active low; clears the configuration registers and the
//   stage valids to zero (no matrix, so every point is rejected) and empties both queues.
// Stalls:
//   When the receiver stops popping, the output queue fills, the back end
//   freezes, then the middle queue fills and in_full rises.
// ----------------------------------------------------------------------------
module perspective_project_to_screen_core
  import ppts_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [31:0]          in_pos_x,
  input  logic [31:0]          in_pos_y,
  input  logic [31:0]          in_pos_z,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_visible,
  output logic [31:0]          out_screen_x,
  output logic [31:0]          out_screen_y,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int CLIP_W = 66 - FRAC_BITS;
  localparam int BEAT_W = 1 + 3 * CLIP_W;
  localparam int QDEPTH = 4;

  logic [63:0] row0_xy_r, row0_zt_r, row1_xy_r, row1_zt_r, row3_xy_r, row3_zt_r;
  logic [31:0] screen_r;
  logic        loaded_r;

  logic              mq_push, mq_full, mq_pop, mq_empty;
  logic [BEAT_W-1:0] mq_wdata, mq_rdata;
  logic              oq_push, oq_full;
  logic [64:0]       oq_wdata, oq_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_xy_r <= '0;
      row0_zt_r <= '0;
      row1_xy_r <= '0;
      row1_zt_r <= '0;
      row3_xy_r <= '0;
      row3_zt_r <= '0;
      screen_r  <= '0;
      loaded_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_XY: row0_xy_r <= cfg_data;
        REG_ROW0_ZT: row0_zt_r <= cfg_data;
        REG_ROW1_XY: row1_xy_r <= cfg_data;
        REG_ROW1_ZT: row1_zt_r <= cfg_data;
        REG_ROW3_XY: row3_xy_r <= cfg_data;
        REG_ROW3_ZT: row3_zt_r <= cfg_data;
        REG_SCREEN:  screen_r  <= cfg_data[31:0];
        REG_LOADED:  loaded_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ppts_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .row0_xy       (row0_xy_r),
    .row0_zt       (row0_zt_r),
    .row1_xy       (row1_xy_r),
    .row1_zt       (row1_zt_r),
    .row3_xy       (row3_xy_r),
    .row3_zt       (row3_zt_r),
    .matrix_loaded (loaded_r),
    .q_push        (mq_push),
    .q_wdata       (mq_wdata),
    .q_full        (mq_full)
  );

  // Queue between classification and division.
  ppts_fifo #(
    .WIDTH (BEAT_W),
    .DEPTH (QDEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  ppts_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (mq_empty),
    .q_pop       (mq_pop),
    .q_rdata     (mq_rdata),
    .screen_size (screen_r),
    .o_push      (oq_push),
    .o_wdata     (oq_wdata),
    .o_full      (oq_full)
  );

  // Output queue parts the back end from the receiver.
  ppts_fifo #(
    .WIDTH (65),
    .DEPTH (QDEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (oq_rdata),
    .empty (out_empty)
  );

  assign out_visible  = oq_rdata[64];
  assign out_screen_x = oq_rdata[63:32];
  assign out_screen_y = oq_rdata[31:0];

endmodule

/* sim/perspective_project_to_screen_core_tb.sv */
// ----------------------------------------------------------------------------
// perspective_project_to_screen_core_tb
// Self-checking bench for the perspective projection core. A directed table
// of matrix writes and points runs first, then randomized matrix phases with
// random points. Every result beat is checked against a typed expected value
// or an in-bench projection model, with bursty input traffic and a receiver that stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module perspective_project_to_screen_core_tb;
  import ppts_pkg::*;

  localparam int  FRAC      = FRAC_BITS_DEF;
  localparam int  DRAIN_CYC = 70;
  localparam int  NUM_RAND  = 650;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

  typedef struct {
    logic        visible;
    logic [31:0] screen_x;
    logic [31:0] screen_y;
  } proj_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    idx;
    logic [63:0] data;
    logic [31:0] x, y, z;
    bit          typed;
    proj_t       want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic        out_empty;
  logic        out_pop;
  logic        out_visible;
  logic [31:0] out_screen_x, out_screen_y;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  // Shadow copy of the configuration registers.
  logic [63:0] mat_regs [8];

  proj_t       pending_q[$];
  stim_row_t   stim_tab[$];
  int          err_count = 0;
  int          burst_left = 0;
  int          rx_cycle = 0;

  perspective_project_to_screen_core DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL perspective_project_to_screen_core");
    $finish;
  end

  // Clip coordinate: each product floored to FRAC bits, then summed exactly.
  function automatic longint clip_dot(logic [63:0] xy, logic [63:0] zt,
                                      longint px, longint py, longint pz);
    longint s;
    s = (longint'($signed(xy[31:0])) * px) >>> FRAC;
    s += (longint'($signed(xy[63:32])) * py) >>> FRAC;
    s += (longint'($signed(zt[31:0])) * pz) >>> FRAC;
    s += longint'($signed(zt[63:32]));
    return s;
  endfunction

  // Fixed point quotient truncated toward zero, magnitude clamped to 2^46.
  function automatic longint clip_ratio(longint num, longint w);
    logic [127:0] mag, q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    if (mag / 128'(w) >= (128'd1 << (46 - FRAC))) q = 128'd1 << 46;
    else q = (mag << FRAC) / 128'(w);
    return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic proj_t project_point(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z);
    proj_t  p;
    longint px, py, pz, w, rx, ry, sw, sh, one;
    px = longint'($signed(x));
    py = longint'($signed(y));
    pz = longint'($signed(z));
    one = longint'(1) << FRAC;
    p = '{1'b0, 32'd0, 32'd0};
    if (!mat_regs[REG_LOADED][0]) return p;
    w = clip_dot(mat_regs[REG_ROW3_XY], mat_regs[REG_ROW3_ZT], px, py, pz);
    if (w * 100 < one) return p;
    rx = clip_ratio(clip_dot(mat_regs[REG_ROW0_XY], mat_regs[REG_ROW0_ZT], px, py, pz), w);
    ry = clip_ratio(clip_dot(mat_regs[REG_ROW1_XY], mat_regs[REG_ROW1_ZT], px, py, pz), w);
    sw = longint'(mat_regs[REG_SCREEN][15:0]);
    sh = longint'(mat_regs[REG_SCREEN][31:16]);
    p.visible  = 1'b1;
    p.screen_x = sat32((sw * one + rx * sw + one) >>> 1);
    p.screen_y = sat32((sh * one - ry * sh - one) >>> 1);
    return p;
  endfunction

  // Random signed value of the given width, sign-extended to 32 bits.
  function automatic logic [31:0] rand_signed(int bits);
    logic [31:0] v;
    v = $urandom;
    return $signed(v << (32 - bits)) >>> (32 - bits);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return rand_signed(20);
      default: return rand_signed(25);
    endcase
  endfunction

  function automatic void add_cfg(cfg_idx_t idx, logic [63:0] data);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    stim_tab.push_back(r);
  endfunction

  function automatic void add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                    bit typed = 0, proj_t want = '{1'b0, 32'd0, 32'd0});
    stim_row_t r;
    r.kind  = ROW_POINT;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    r.typed = typed;
    r.want  = want;
    stim_tab.push_back(r);
  endfunction

  // Wait until every expected beat has left, plus the pipeline depth.
  task automatic wait_idle();
    in_push <= 1'b0;
    cfg_we  <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // The write enable stays high for back to back writes; the caller's next
  // step drops it.
  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == REG_SCREEN) mat_regs[idx] = {32'd0, data[31:0]};
    else if (idx == REG_LOADED) mat_regs[idx] = {63'd0, data[0]};
    else mat_regs[idx] = data;
  endtask

  // Send one input beat; bursts of random length with random gaps between.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            bit typed, proj_t want);
    cfg_we   <= 1'b0;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_push  <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    pending_q.push_back(typed ? want : project_point(x, y, z));
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver: pops always, at random, or on a fixed on/off pattern.
  always @(posedge clk) begin
    proj_t exp_beat;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: visible=%0b x=%h y=%h",
               out_visible, out_screen_x, out_screen_y);
        err_count++;
      end else begin
        exp_beat = pending_q.pop_front();
        if (out_visible !== exp_beat.visible) begin
          $error("visible: expected %0b, got %0b", exp_beat.visible, out_visible);
          err_count++;
        end
        if (out_screen_x !== exp_beat.screen_x) begin
          $error("screen_x: expected %h, got %h", exp_beat.screen_x, out_screen_x);
          err_count++;
        end
        if (out_screen_y !== exp_beat.screen_y) begin
          $error("screen_y: expected %h, got %h", exp_beat.screen_y, out_screen_y);
          err_count++;
        end
      end
    end
    rx_cycle++;
    case ((rx_cycle / 300) % 3)
      0:       out_pop <= 1'b1;
      1:       out_pop <= $urandom_range(0, 1);
      default: out_pop <= (rx_cycle % 8) < 3;
    endcase
  end

  initial begin
    proj_t hidden;
    int    sent;
    int    n;
    logic [63:0] t;

    hidden = '{1'b0, 32'd0, 32'd0};
    rst_n = 1'b0;
    in_push = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    foreach (mat_regs[i]) mat_regs[i] = '0;

    // After reset no matrix is present, so every point is rejected.
    add_point(32'd0, 32'd0, 32'd0, 1, hidden);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1, hidden);
    // Plain matrix: x and y pass through, w is one, 640 by 480 screen.
    add_cfg(REG_ROW0_XY, {32'd0, ONE});
    add_cfg(REG_ROW0_ZT, 64'd0);
    add_cfg(REG_ROW1_XY, {ONE, 32'd0});
    add_cfg(REG_ROW1_ZT, 64'd0);
    add_cfg(REG_ROW3_XY, 64'd0);
    add_cfg(REG_ROW3_ZT, {ONE, 32'd0});
    add_cfg(REG_SCREEN, {32'hDEAD_BEEF, 16'd480, 16'd640});
    // Over-wide write of the loaded flag keeps only bit 0, which is clear.
    add_cfg(REG_LOADED, 64'hFFFF_FFFF_FFFF_FFFE);
    add_point(32'd0, 32'd0, 32'd0, 1, hidden);
    add_cfg(REG_LOADED, 64'd1);
    add_point(32'd0, 32'd0, 32'd0, 1, '{1'b1, 32'h0140_8000, 32'h00EF_8000});
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_point(ONE >> 1, 32'hFFFF_8000, 32'd5);
    // w follows z: just below and just above the 0.01 threshold.
    add_cfg(REG_ROW3_ZT, {32'd0, ONE});
    add_point(ONE, ONE, 32'd655, 1, hidden);
    add_point(ONE, ONE, 32'd656);
    add_point(ONE, ONE, 32'hFFFF_0000, 1, hidden);
    add_point(ONE, ONE, 32'd0, 1, hidden);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd656);
    // Zero screen size, then the largest one.
    add_cfg(REG_SCREEN, 64'd0);
    add_point(32'h0123_4567, 32'hFEDC_BA98, ONE);
    add_cfg(REG_SCREEN, 64'hFFFF_FFFF_FFFF_FFFF);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd700);
    add_point(32'd3, 32'hFFFF_FFFD, 32'h7FFF_FFFF);
    // Extreme coefficients.
    add_cfg(REG_ROW0_XY, 64'h8000_0000_7FFF_FFFF);
    add_cfg(REG_ROW1_ZT, 64'h7FFF_FFFF_8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000, ONE);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(stim_tab[i].idx, stim_tab[i].data);
      end else begin
        send_point(stim_tab[i].x, stim_tab[i].y, stim_tab[i].z,
                   stim_tab[i].typed, stim_tab[i].want);
      end
    end

    // Random phases: a fresh matrix, then a run of points.
    sent = 0;
    while (sent < NUM_RAND) begin
      wait_idle();
      for (int r = 0; r < 3; r++) begin
        write_reg(cfg_idx_t'(2 * r),
                  $urandom_range(0, 4) == 0 ? {$urandom, $urandom}
                                            : {rand_signed(20), rand_signed(20)});
        write_reg(cfg_idx_t'(2 * r + 1),
                  $urandom_range(0, 4) == 0 ? {$urandom, $urandom}
                                            : {rand_signed(26), rand_signed(20)});
      end
      // Keep w mostly positive: small slopes plus a positive offset.
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_ROW3_XY, {rand_signed(12), rand_signed(12)});
        t = {32'($urandom_range(1, 64 * 65536)), rand_signed(12)};
        write_reg(REG_ROW3_ZT, t);
      end
      case ($urandom_range(0, 5))
        0:       write_reg(REG_SCREEN, {$urandom, 32'd0});
        1:       write_reg(REG_SCREEN, {$urandom, 32'hFFFF_FFFF});
        default: write_reg(REG_SCREEN, {$urandom, $urandom});
      endcase
      write_reg(REG_LOADED, {$urandom, $urandom} | 64'($urandom_range(0, 9) != 0));
      n = $urandom_range(40, 90);
      for (int k = 0; k < n; k++) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 0, hidden);
        sent++;
      end
    end

    // Drain and finish.
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS perspective_project_to_screen_core");
    end else begin
      $display("FAIL perspective_project_to_screen_core");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ppts_pkg.sv
hw/rtl/ppts_fifo.sv
hw/rtl/ppts_front.sv
hw/rtl/ppts_div.sv
hw/rtl/ppts_back.sv
hw/rtl/perspective_project_to_screen_core.sv
sim/perspective_project_to_screen_core_tb.sv
